[hdl/rv32ie_pkg.sv]
// Shared types and constants of the RV32I execute block.
// No dependencies; used by rv32i_instruction_execute.
package rv32ie_pkg;

	localparam int DATA_WORDS = 16384;
	localparam int REG_COUNT  = 32;
	localparam int DW_AW      = $clog2(DATA_WORDS);
	localparam int RF_AW      = $clog2(REG_COUNT);
	localparam int CFG_IDX_W  = 2;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 72;

	localparam logic [CFG_IDX_W-1:0] CFG_CODE_BASE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STACK_TOP     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_WORDS = 2'd2;

	typedef enum logic [5:0] {
		CMD_START = 6'd0, CMD_LUI = 6'd1, CMD_AUIPC = 6'd2, CMD_JAL = 6'd3,
		CMD_JALR = 6'd4, CMD_RET = 6'd5, CMD_BEQ = 6'd6, CMD_BNE = 6'd7,
		CMD_BLT = 6'd8, CMD_BGE = 6'd9, CMD_BLTU = 6'd10, CMD_BGEU = 6'd11,
		CMD_LB = 6'd12, CMD_LH = 6'd13, CMD_LW = 6'd14, CMD_LBU = 6'd15,
		CMD_LHU = 6'd16, CMD_SB = 6'd17, CMD_SH = 6'd18, CMD_SW = 6'd19,
		CMD_ADDI = 6'd20, CMD_SLTI = 6'd21, CMD_SLTIU = 6'd22, CMD_XORI = 6'd23,
		CMD_ORI = 6'd24, CMD_ANDI = 6'd25, CMD_SLLI = 6'd26, CMD_SRLI = 6'd27,
		CMD_SRAI = 6'd28, CMD_ADD = 6'd29, CMD_SUB = 6'd30, CMD_SLL = 6'd31,
		CMD_SLT = 6'd32, CMD_SLTU = 6'd33, CMD_XOR = 6'd34, CMD_SRL = 6'd35,
		CMD_SRA = 6'd36, CMD_OR = 6'd37, CMD_AND = 6'd38, CMD_FENCE = 6'd39,
		CMD_FENCE_TSO = 6'd40, CMD_PAUSE = 6'd41, CMD_ECALL = 6'd42,
		CMD_EBREAK = 6'd43
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_HALTED = 3'd1, ST_BELOW_BASE = 3'd2, ST_MISALIGNED = 3'd3,
		ST_PAST_END = 3'd4, ST_TRAP = 3'd5, ST_UNKNOWN = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		LD_B = 3'd0, LD_H = 3'd1, LD_W = 3'd2, LD_BU = 3'd3, LD_HU = 3'd4
	} ld_kind_t;

	typedef struct packed {
		status_t          status;
		logic [31:0]      next_pc;
		logic             br;
		logic             wr;
		logic [RF_AW-1:0] idx;
		logic [31:0]      val;
	} result_t;

	typedef struct packed {
		logic             valid;
		logic [RF_AW-1:0] idx;
		logic [31:0]      val;
	} rf_fwd_t;

endpackage

[hdl/rv32i_instruction_execute.sv]
// Top level of the RV32I execute block: pipeline, register file and data store.
// Depends on rv32ie_pkg and rv32ie_ram.

// Executes one decoded RV32I instruction per item and returns one result item for
// each, in order. Sustained rate is one item per clock while the output is not held
// back by m_tready, including loads and stores and back-to-back dependent
// instructions. Items pass a read stage (register file read from RAM), an execute
// stage (ALU, branch, pc checks, data store access) and a load-alignment stage,
// then an output register. The register file sits in two RAM copies with
// forwarding from later stages; the data store is four byte-wide RAMs, so a
// misaligned access is served in one access to all four lanes. Register file
// contents read as zero after reset; data store words that were never written
// read as undefined.
module rv32i_instruction_execute (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// dest_index[4:0], src1_index[9:5], src2_index[14:10], immediate[46:15]
	input  logic [rv32ie_pkg::IN_DATA_W-1:0]     s_tdata,
	// command[5:0]
	input  logic [5:0]                           s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// next_pc[31:0], pc_redirect[32], reg_written[33], written_index[38:34],
	// written_value[70:39]
	output logic [rv32ie_pkg::OUT_DATA_W-1:0]    m_tdata,
	// status[2:0]
	output logic [2:0]                           m_tuser,
	input  logic                                 cfg_we,
	input  logic [rv32ie_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                          cfg_data
);
	import rv32ie_pkg::*;

	// configuration and architectural control state
	logic [31:0] code_base_q, stack_top_q, pc_q;
	logic [16:0] program_words_q;
	logic        halted_q;
	logic [REG_COUNT-1:0] rf_valid_q;

	// handshake
	logic accept, s1_adv, s2_adv;
	logic s1_valid_q, s2_valid_q, out_valid_q;

	// stage 1 registers
	cmd_t             cmd_s1;
	logic [RF_AW-1:0] rd_s1, rs1_s1, rs2_s1;
	logic [31:0]      imm_s1;
	logic             v1ok_s1, v2ok_s1;
	rf_fwd_t          byp_s1;

	// stage 2 registers
	result_t    res_s2;
	logic       load_s2;
	ld_kind_t   ldk_s2;
	logic [1:0] off_s2;

	result_t out_q;

	// register file RAMs
	logic [31:0]      rf1_rdata, rf2_rdata;
	logic             rf_we;
	logic [RF_AW-1:0] rf_wa;
	logic [31:0]      rf_wd;

	// data store lanes
	logic [3:0]       lane_we;
	logic             lane_re;
	logic [DW_AW-1:0] lane_addr [4];
	logic [7:0]       lane_wd   [4];
	logic [7:0]       lane_rd   [4];

	// stage 1 combinational results
	logic [31:0] a, b, addr, off, sum_ab, s1_val, s1_npc, s1_pc_next;
	status_t     s1_stat;
	logic        s1_br, s1_wr, s1_load, s1_store, s1_halt_next;
	ld_kind_t    s1_ldk;
	logic [2:0]  s1_nbytes;
	logic [31:0] s2_wval, ld_val;

	assign s2_adv   = s2_valid_q && (!out_valid_q || m_tready);
	assign s1_adv   = s1_valid_q && (!s2_valid_q || s2_adv);
	assign s_tready = !s1_valid_q || s1_adv;
	assign accept   = s_tvalid && s_tready;

	assign rf_we = s2_adv && res_s2.wr;
	assign rf_wa = res_s2.idx;
	assign rf_wd = s2_wval;

	rv32ie_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf1 (
		.clk(clk), .we(rf_we), .waddr(rf_wa), .wdata(rf_wd),
		.re(accept), .raddr(s_tdata[9:5]), .rdata(rf1_rdata)
	);

	rv32ie_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf2 (
		.clk(clk), .we(rf_we), .waddr(rf_wa), .wdata(rf_wd),
		.re(accept), .raddr(s_tdata[14:10]), .rdata(rf2_rdata)
	);

	for (genvar j = 0; j < 4; j++) begin : g_lane
		rv32ie_ram #(.WIDTH(8), .DEPTH(DATA_WORDS)) u_lane (
			.clk(clk), .we(lane_we[j]), .waddr(lane_addr[j]), .wdata(lane_wd[j]),
			.re(lane_re), .raddr(lane_addr[j]), .rdata(lane_rd[j])
		);
	end

	// operand forwarding: the item in stage 2 first, then a write that landed
	// at the edge the read was issued
	always_comb begin
		a = v1ok_s1 ? rf1_rdata : '0;
		b = v2ok_s1 ? rf2_rdata : '0;
		if (byp_s1.valid && byp_s1.idx == rs1_s1) begin
			a = byp_s1.val;
		end
		if (byp_s1.valid && byp_s1.idx == rs2_s1) begin
			b = byp_s1.val;
		end
		if (s2_valid_q && res_s2.wr && res_s2.idx == rs1_s1) begin
			a = s2_wval;
		end
		if (s2_valid_q && res_s2.wr && res_s2.idx == rs2_s1) begin
			b = s2_wval;
		end
	end

	always_comb begin
		addr      = a + imm_s1;
		sum_ab    = pc_q + imm_s1;
		off       = pc_q - code_base_q;
		s1_val    = '0;
		s1_wr     = 1'b0;
		s1_br     = 1'b0;
		s1_load   = 1'b0;
		s1_store  = 1'b0;
		s1_ldk    = LD_W;
		s1_nbytes = 3'd0;
		s1_npc    = pc_q + 32'd4;
		s1_stat   = ST_OK;
		priority if (cmd_s1 == CMD_START) begin
			s1_npc = code_base_q;
		end else if (halted_q) begin
			s1_stat = ST_HALTED;
		end else if (pc_q < code_base_q) begin
			s1_stat = ST_BELOW_BASE;
		end else if (off[1:0] != 2'd0) begin
			s1_stat = ST_MISALIGNED;
		end else if (off[31:2] >= {13'd0, program_words_q}) begin
			s1_stat = ST_PAST_END;
		end else begin
			unique case (cmd_s1)
				CMD_LUI:   begin s1_val = imm_s1; s1_wr = 1'b1; end
				CMD_AUIPC: begin s1_val = sum_ab; s1_wr = 1'b1; end
				CMD_JAL: begin
					s1_val = pc_q + 32'd4; s1_wr = 1'b1; s1_npc = sum_ab; s1_br = 1'b1;
				end
				CMD_JALR: begin
					s1_val = pc_q + 32'd4; s1_wr = 1'b1; s1_br = 1'b1;
					s1_npc = {addr[31:1], 1'b0};
				end
				CMD_RET:   s1_stat = ST_HALTED;
				CMD_BEQ:   s1_br = (a == b);
				CMD_BNE:   s1_br = (a != b);
				CMD_BLT:   s1_br = ($signed(a) < $signed(b));
				CMD_BGE:   s1_br = !($signed(a) < $signed(b));
				CMD_BLTU:  s1_br = (a < b);
				CMD_BGEU:  s1_br = (a >= b);
				CMD_LB:    begin s1_load = 1'b1; s1_ldk = LD_B;  s1_wr = 1'b1; end
				CMD_LH:    begin s1_load = 1'b1; s1_ldk = LD_H;  s1_wr = 1'b1; end
				CMD_LW:    begin s1_load = 1'b1; s1_ldk = LD_W;  s1_wr = 1'b1; end
				CMD_LBU:   begin s1_load = 1'b1; s1_ldk = LD_BU; s1_wr = 1'b1; end
				CMD_LHU:   begin s1_load = 1'b1; s1_ldk = LD_HU; s1_wr = 1'b1; end
				CMD_SB:    begin s1_store = 1'b1; s1_nbytes = 3'd1; end
				CMD_SH:    begin s1_store = 1'b1; s1_nbytes = 3'd2; end
				CMD_SW:    begin s1_store = 1'b1; s1_nbytes = 3'd4; end
				CMD_ADDI:  begin s1_val = addr; s1_wr = 1'b1; end
				CMD_SLTI: begin
					s1_val = {31'd0, $signed(a) < $signed(imm_s1)}; s1_wr = 1'b1;
				end
				CMD_SLTIU: begin s1_val = {31'd0, a < imm_s1}; s1_wr = 1'b1; end
				CMD_XORI:  begin s1_val = a ^ imm_s1; s1_wr = 1'b1; end
				CMD_ORI:   begin s1_val = a | imm_s1; s1_wr = 1'b1; end
				CMD_ANDI:  begin s1_val = a & imm_s1; s1_wr = 1'b1; end
				CMD_SLLI:  begin s1_val = a << imm_s1[4:0]; s1_wr = 1'b1; end
				CMD_SRLI:  begin s1_val = a >> imm_s1[4:0]; s1_wr = 1'b1; end
				CMD_SRAI: begin
					s1_val = 32'($signed(a) >>> imm_s1[4:0]); s1_wr = 1'b1;
				end
				CMD_ADD:   begin s1_val = a + b; s1_wr = 1'b1; end
				CMD_SUB:   begin s1_val = a - b; s1_wr = 1'b1; end
				CMD_SLL:   begin s1_val = a << b[4:0]; s1_wr = 1'b1; end
				CMD_SLT: begin
					s1_val = {31'd0, $signed(a) < $signed(b)}; s1_wr = 1'b1;
				end
				CMD_SLTU:  begin s1_val = {31'd0, a < b}; s1_wr = 1'b1; end
				CMD_XOR:   begin s1_val = a ^ b; s1_wr = 1'b1; end
				CMD_SRL:   begin s1_val = a >> b[4:0]; s1_wr = 1'b1; end
				CMD_SRA:   begin s1_val = 32'($signed(a) >>> b[4:0]); s1_wr = 1'b1; end
				CMD_OR:    begin s1_val = a | b; s1_wr = 1'b1; end
				CMD_AND:   begin s1_val = a & b; s1_wr = 1'b1; end
				CMD_FENCE, CMD_FENCE_TSO, CMD_PAUSE: ;
				CMD_ECALL, CMD_EBREAK: s1_stat = ST_TRAP;
				default:   s1_stat = ST_UNKNOWN;
			endcase
			if (s1_br && cmd_s1 >= CMD_BEQ && cmd_s1 <= CMD_BGEU) begin
				s1_npc = sum_ab;
			end
		end
		if (cmd_s1 != CMD_START && s1_stat != ST_OK) begin
			s1_npc = pc_q;
			s1_br  = 1'b0;
			s1_wr  = 1'b0;
		end
		if (cmd_s1 != CMD_START && (!s1_wr || rd_s1 == '0)) begin
			s1_wr  = 1'b0;
			s1_val = '0;
		end
		s1_pc_next   = (cmd_s1 == CMD_START || s1_stat == ST_OK) ? s1_npc : pc_q;
		s1_halt_next = (cmd_s1 == CMD_START) ? 1'b0 :
			(cmd_s1 == CMD_RET && s1_stat == ST_HALTED) ? 1'b1 : halted_q;
	end

	// byte lanes: lane j holds byte k = j - addr[1:0] of the access
	always_comb begin
		logic [1:0] k;
		logic [31:0] sh;
		lane_re = s1_adv && s1_load && s1_stat == ST_OK;
		for (int j = 0; j < 4; j++) begin
			k  = 2'(j) - addr[1:0];
			sh = b >> {k, 3'b000};
			lane_addr[j] = addr[DW_AW+1:2] + DW_AW'(2'(j) < addr[1:0]);
			lane_wd[j]   = sh[7:0];
			lane_we[j]   = s1_adv && s1_store && s1_stat == ST_OK && {1'b0, k} < s1_nbytes;
		end
	end

	// load alignment in stage 2
	always_comb begin
		logic [7:0] by [4];
		for (int k = 0; k < 4; k++) begin
			by[k] = lane_rd[2'(off_s2 + 2'(k))];
		end
		unique case (ldk_s2)
			LD_B:    ld_val = {{24{by[0][7]}}, by[0]};
			LD_H:    ld_val = {{16{by[1][7]}}, by[1], by[0]};
			LD_W:    ld_val = {by[3], by[2], by[1], by[0]};
			LD_BU:   ld_val = {24'd0, by[0]};
			LD_HU:   ld_val = {16'd0, by[1], by[0]};
			default: ld_val = {by[3], by[2], by[1], by[0]};
		endcase
		s2_wval = !res_s2.wr ? 32'd0 : (load_s2 ? ld_val : res_s2.val);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_base_q     <= '0;
			stack_top_q     <= '0;
			program_words_q <= '0;
			pc_q            <= '0;
			halted_q        <= 1'b0;
			rf_valid_q      <= '0;
			s1_valid_q      <= 1'b0;
			s2_valid_q      <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_CODE_BASE:     code_base_q     <= cfg_data;
					CFG_STACK_TOP:     stack_top_q     <= cfg_data;
					CFG_PROGRAM_WORDS: program_words_q <= cfg_data[16:0];
					default: ;
				endcase
			end
			if (s1_adv) begin
				pc_q     <= s1_pc_next;
				halted_q <= s1_halt_next;
			end
			if (rf_we) begin
				rf_valid_q[rf_wa] <= 1'b1;
			end
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				s2_valid_q <= 1'b1;
			end else if (s2_adv) begin
				s2_valid_q <= 1'b0;
			end
			if (s2_adv) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= cmd_t'(s_tuser);
			rd_s1      <= s_tdata[4:0];
			rs1_s1     <= s_tdata[9:5];
			rs2_s1     <= s_tdata[14:10];
			imm_s1     <= s_tdata[46:15];
			v1ok_s1    <= rf_valid_q[s_tdata[9:5]];
			v2ok_s1    <= rf_valid_q[s_tdata[14:10]];
			byp_s1     <= '{valid: rf_we, idx: rf_wa, val: rf_wd};
		end
		if (s1_adv) begin
			if (cmd_s1 == CMD_START) begin
				res_s2 <= '{status: ST_OK, next_pc: code_base_q, br: 1'b0, wr: 1'b1,
					idx: RF_AW'(2), val: stack_top_q};
			end else begin
				res_s2 <= '{status: s1_stat, next_pc: s1_npc, br: s1_br, wr: s1_wr,
					idx: s1_wr ? rd_s1 : '0, val: s1_val};
			end
			load_s2 <= s1_load && cmd_s1 != CMD_START && s1_stat == ST_OK;
			ldk_s2  <= s1_ldk;
			off_s2  <= addr[1:0];
		end
		if (s2_adv) begin
			out_q <= '{status: res_s2.status, next_pc: res_s2.next_pc, br: res_s2.br,
				wr: res_s2.wr, idx: res_s2.idx, val: s2_wval};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {1'b0, out_q.val, out_q.idx, out_q.wr, out_q.br, out_q.next_pc};

`ifndef SYNTHESIS
	a_rf_no_x0: assert property (@(posedge clk) disable iff (!arst_n)
		rf_we |-> rf_wa != '0)
		else $error("register file write to x0");
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_q |-> s_tready)
		else $error("input stalled with empty stage 1");
	a_ret_halts: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && cmd_s1 == CMD_RET && s1_stat == ST_HALTED |=> halted_q)
		else $error("RET did not halt");
	a_lane_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(|lane_we) |-> !lane_re)
		else $error("data store read and write in one cycle");
	a_branch_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.br |-> out_q.status == ST_OK)
		else $error("branch taken on a failed item");
`endif

endmodule

[hdl/rv32ie_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module rv32ie_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
